// ===== hdl/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared constants for the pid drive core: register indexes, field widths
// and the integral limit scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

    localparam int ErrorW   = 16;   // error sample, Q8.8
    localparam int GainW    = 16;   // gains, Q8.8
    localparam int PropW    = 17;   // negated error, Q9.8
    localparam int DerivW   = 18;   // error difference, Q10.8
    localparam int IntegW   = 32;   // integral, Q16.16
    localparam int IProdW   = 33;   // gain_i * p
    localparam int LimitW   = 31;   // clamp limit
    localparam int DriveW   = 34;   // drive, Q18.16
    localparam int CfgDataW = 31;   // widest register
    localparam int CfgIdxW  = 2;

    // 0.8 in Q0.16, applied as (output limit * LimitMul) >> 16
    localparam int LimitMul      = 52429;
    localparam int OutLimitReset = 65536;
    localparam logic [LimitW-1:0] LimitReset =
        LimitW'((64'(OutLimitReset) * 64'(LimitMul)) >> 16);

    typedef enum logic [CfgIdxW-1:0] {
        REG_GAIN_P    = 2'd0,
        REG_GAIN_I    = 2'd1,
        REG_GAIN_D    = 2'd2,
        REG_OUT_LIMIT = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/pidc_integ.sv =====
// ----------------------------------------------------------------------------
// pidc_integ
// Integral accumulator with symmetric anti-windup clamp. One update per load.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_integ
    import pidc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     load,
    input  wire logic signed [IProdW-1:0] prod,
    input  wire logic        [LimitW-1:0] limit,
    output logic signed      [IntegW-1:0] integ_next
);

    localparam int AccW = IProdW + 1;

    logic signed [IntegW-1:0] integ_reg;
    logic signed [AccW-1:0]   acc;
    logic signed [AccW-1:0]   lim_pos;
    logic signed [AccW-1:0]   lim_neg;

    always_comb begin
        acc     = AccW'(integ_reg) + AccW'(prod);
        lim_pos = signed'({{(AccW-LimitW){1'b0}}, limit});
        lim_neg = -lim_pos;
        if (acc > lim_pos) begin
            integ_next = IntegW'(lim_pos);
        end else if (acc < lim_neg) begin
            integ_next = IntegW'(lim_neg);
        end else begin
            integ_next = IntegW'(acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (load) begin
            integ_reg <= integ_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pid_with_integral_clamp_core.sv =====
// ----------------------------------------------------------------------------
// pid_with_integral_clamp_core
// PID drive: proportional, clamped integral and derivative terms per sample.
// ----------------------------------------------------------------------------
// path: an accepted item passes the input register, then the result register
// throughput: one item per cycle while m_tready allows; an input register and
//   a result register with all products, clamp and sum between, in one pass
// stalls: while the result waits on m_tready, s_tready is low once the input
//   register holds an item
// reset: gains zero, output limit 65536, integral and previous error cleared,
//   first sample after reset has zero derivative; no clearing pass
`default_nettype none

module pid_with_integral_clamp_core
    import pidc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata,
    // input samples
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [15:0]         s_tdata,   // [15:0] error_sample
    // results
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata    // [33:0] drive, [39:34] zero
);

    localparam int PProdW = GainW + PropW;
    localparam int DProdW = GainW + DerivW;
    localparam int LimProdW = CfgDataW + 16;

    // configuration registers
    logic signed [GainW-1:0]  gain_p_reg;
    logic signed [GainW-1:0]  gain_i_reg;
    logic signed [GainW-1:0]  gain_d_reg;
    logic        [LimitW-1:0] limit_reg;
    logic        [LimProdW-1:0] lim_prod;

    assign lim_prod = LimProdW'(cfg_wdata) * LimProdW'(LimitMul);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= LimitReset;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:    gain_p_reg <= signed'(cfg_wdata[GainW-1:0]);
                REG_GAIN_I:    gain_i_reg <= signed'(cfg_wdata[GainW-1:0]);
                REG_GAIN_D:    gain_d_reg <= signed'(cfg_wdata[GainW-1:0]);
                REG_OUT_LIMIT: limit_reg  <= lim_prod[LimProdW-1:16];
                default: ;
            endcase
        end
    end

    // handshakes: input register a, result register m
    logic a_valid_reg, m_valid_reg;
    logic m_free, a_ready;
    logic s_accept, m_load;

    assign m_free   = !m_valid_reg || m_tready;
    assign a_ready  = !a_valid_reg || m_free;
    assign s_tready = a_ready;
    assign s_accept = s_tvalid && a_ready;
    assign m_load   = a_valid_reg && m_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= s_tvalid;
            if (m_free)  m_valid_reg <= a_valid_reg;
        end
    end

    // input register: negate sample, form difference from previous error
    logic signed [PropW-1:0]  p_next;
    logic signed [DerivW-1:0] d_next;
    logic signed [PropW-1:0]  prev_err_reg;
    logic                     started_reg;
    logic signed [PropW-1:0]  a_p_reg;
    logic signed [DerivW-1:0] a_d_reg;

    always_comb begin
        p_next = -PropW'(signed'(s_tdata[ErrorW-1:0]));
        d_next = started_reg ? (DerivW'(p_next) - DerivW'(prev_err_reg)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            started_reg  <= 1'b0;
        end else if (s_accept) begin
            prev_err_reg <= p_next;
            started_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_p_reg <= p_next;
            a_d_reg <= d_next;
        end
    end

    // three independent products, integral update and final sum
    logic signed [PProdW-1:0] pp;
    logic signed [IProdW-1:0] ip;
    logic signed [DProdW-1:0] dp;
    logic signed [IntegW-1:0] integ_next;
    logic signed [DriveW-1:0] drive_next;
    logic signed [DriveW-1:0] drive_reg;

    always_comb begin
        pp = PProdW'(gain_p_reg) * PProdW'(a_p_reg);
        ip = IProdW'(gain_i_reg) * IProdW'(a_p_reg);
        dp = DProdW'(gain_d_reg) * DProdW'(a_d_reg);
    end

    pidc_integ u_integ (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (m_load),
        .prod       (ip),
        .limit      (limit_reg),
        .integ_next (integ_next)
    );

    assign drive_next = DriveW'(pp) + DriveW'(dp) + DriveW'(integ_next);

    always_ff @(posedge aclk) begin
        if (m_load) begin
            drive_reg <= drive_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(40-DriveW){1'b0}}, drive_reg};

`ifndef ASSERT_OFF
    logic signed [IntegW+1:0] lim_chk;
    assign lim_chk = signed'({3'b000, limit_reg});

    // integral stored with each item stays inside the limit
    a_integ_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |-> (integ_next <= lim_chk && integ_next >= -lim_chk))
        else $error("integral outside clamp limit");

    // first sample after reset carries no derivative
    a_first_deriv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !started_reg) |=> (a_d_reg == '0) && started_reg)
        else $error("nonzero derivative on first sample");

    // an accepted item always lands in the input register with its error kept
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> a_valid_reg && (prev_err_reg == a_p_reg))
        else $error("accepted item not captured");
`endif

endmodule

`default_nettype wire

// ===== bench/pid_with_integral_clamp_core_tb.sv =====
// ----------------------------------------------------------------------------
// pid_with_integral_clamp_core_tb
// Drives error samples into the pid drive core and checks every drive result
// against a cycle-free software predictor of the proportional, clamped
// integral and derivative terms. Gains and the output limit change between
// phases, and both stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_with_integral_clamp_core_tb
    import pidc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 5000;
    localparam int MaxOut     = 31'h7fff_ffff;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;   // [15:0] error_sample
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [39:0]         m_tdata;          // [33:0] drive, [39:34] zero

    pid_with_integral_clamp_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor copy of the registers and the loop state
    logic signed [15:0] kp, ki, kd;
    logic [30:0]        out_max;
    logic signed [16:0] last_p;
    logic signed [31:0] integ_acc;
    logic               seen;

    logic [33:0] drive_q[$];
    int          errors      = 0;
    int          items_sent  = 0;
    int          items_done  = 0;
    int          stall_count = 0;
    int          tx_max      = 15;
    int          rx_max      = 15;
    int          rx_hold     = 0;
    int          phases      = 0;

    function automatic logic [33:0] predict_drive(logic signed [15:0] e);
        longint p, d, lim, acc, sum;
        p   = -longint'(e);
        d   = seen ? p - longint'(last_p) : 0;
        lim = (longint'(out_max) * longint'(LimitMul)) >>> 16;
        acc = longint'(integ_acc) + longint'(ki) * p;
        if (acc > lim)
            acc = lim;
        else if (acc < -lim)
            acc = -lim;
        integ_acc = 32'(acc);
        last_p    = 17'(p);
        seen      = 1'b1;
        sum = longint'(kp) * p + acc + longint'(kd) * d;
        return 34'(sum);
    endfunction

    // register writes, accepted samples and results, all seen at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            kp        = '0;
            ki        = '0;
            kd        = '0;
            out_max   = 31'(OutLimitReset);
            last_p    = '0;
            integ_acc = '0;
            seen      = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_GAIN_P:    kp = cfg_wdata[15:0];
                    REG_GAIN_I:    ki = cfg_wdata[15:0];
                    REG_GAIN_D:    kd = cfg_wdata[15:0];
                    REG_OUT_LIMIT: out_max = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(predict_drive(s_tdata));
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual drive %0d",
                             $time, $signed(m_tdata[33:0]));
                end else begin
                    logic [33:0] want;
                    want = drive_q.pop_front();
                    if (m_tdata[33:0] !== want) begin
                        errors++;
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_tdata[33:0]));
                    end
                end
                items_done++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= StallLimit) begin
                $display("%0t: no item moved for %0d cycles", $time, StallLimit);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side: random hold-off after each accepted item
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= (rx_hold == 0);
        end else if (m_tvalid && m_tready) begin
            rx_hold = $urandom_range(0, rx_max);
            m_tready <= (rx_hold == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_error(input logic [15:0] e);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= e;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // hold the sender until every expected result is back and the pipe is empty
    task automatic drain;
        s_tvalid <= 1'b0;
        while (items_done != items_sent) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_config(input logic signed [15:0] gp, input logic signed [15:0] gi,
                              input logic signed [15:0] gd, input logic [30:0] mo);
        logic [30:0] vals[4];
        vals[0] = 31'(gp);
        vals[1] = 31'(gi);
        vals[2] = 31'(gd);
        vals[3] = mo;
        for (int r = 0; r < 4; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CfgIdxW'(r);
            cfg_wdata <= vals[r];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_error;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'h0001;
                endcase
            end
            1, 2, 3: return 16'($signed($urandom_range(0, 510)) - 255);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_gain;
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
                0: return 16'h8000;
                1: return 16'h7fff;
                default: return 16'h0000;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [30:0] rand_limit;
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 1) ? MaxOut : 0);
            1: return 31'($urandom_range(0, 1 << 20));
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 1 << 27));
        endcase
    endfunction

    // first sample after reset: zero derivative, clamp applied right away
    task automatic test_first_sample;
        set_config(16'sd256, 16'sd32767, -16'sd32768, 31'(65536 * 4));
        send_error(16'h8000);
        send_error(16'h7fff);
        send_error(16'hffff);
        send_error(16'h0000);
        send_error(16'h0001);
        drain();
    endtask

    // integral pinned at both limits with the widest limit and extreme gains
    task automatic test_integral_overflow;
        set_config(-16'sd32768, -16'sd32768, 16'sd32767, 31'(MaxOut));
        repeat (3) send_error(16'h8000);
        repeat (3) send_error(16'h7fff);
        send_error(16'h8000);
        send_error(16'h7fff);
        drain();
        set_config(-16'sd32768, 16'sd32767, -16'sd32768, 31'(MaxOut));
        repeat (2) send_error(16'h8000);
        send_error(16'h7fff);
        send_error(16'h8000);
        drain();
    endtask

    // a smaller limit only bites at the next sample; zero limit holds integral at zero
    task automatic test_limit_change;
        set_config(-16'sd32768, 16'sd32767, -16'sd32768, 31'd1000);
        send_error(16'h0000);
        send_error(16'h0005);
        drain();
        set_config(16'sd100, 16'sd32767, 16'sd0, 31'd0);
        send_error(16'h0064);
        send_error(16'hff9c);
        drain();
    endtask

    task automatic test_random_phases;
        int per_phase;
        for (int ph = 0; ph < 8; ph++) begin
            set_config(rand_gain(), rand_gain(), rand_gain(), rand_limit());
            case (ph % 4)
                0: begin tx_max = 0;  rx_max = 0;  end
                1: begin tx_max = 15; rx_max = 0;  end
                2: begin tx_max = 0;  rx_max = 15; end
                default: begin tx_max = 15; rx_max = 15; end
            endcase
            per_phase = 110 + $urandom_range(0, 16);
            for (int n = 0; n < per_phase; n++) begin
                send_error(rand_error());
                if (n == per_phase / 2 && ph == 3)
                    drain();
            end
            drain();
            phases++;
        end
        tx_max = 15;
        rx_max = 15;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_sample();
        test_integral_overflow();
        test_limit_change();
        test_random_phases();

        drain();
        repeat (10) @(posedge aclk);
        if (drive_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived, expected 0, actual %0d",
                     $time, drive_q.size(), drive_q.size());
        end
        $display("covered %0d samples, %0d results, directed limits plus %0d random phases",
                 items_sent, items_done, phases);
        $display("mismatches: %0d", errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
